[sv/gdfw_pkg.sv]
// Package for the depth-first graph walker: sizes, input kinds, helper types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gdfw_pkg;
  localparam int NODES_DEF      = 64;
  localparam int EDGE_SLOTS_DEF = 512;
  localparam int NODE_W         = 6;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_RUN   = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;
endpackage
`default_nettype wire

[sv/graph_depth_first_walk_top.sv]
// Top level of the depth-first graph walker: edge loader, walk sequencer, memories.
// Depends on gdfw_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Beat contents
// in_*      in   tdata = {node_b, node_a} (bits 5:0 node_a, 11:6 node_b), tuser = kind
// out_*     out  tdata = visited_node (5:0), tlast = last, tuser = overflow
//
// Steps: an add beat is accepted with the chain head read, then writes the slot
// and head for a, then for b; a clear, ignored or already visited run beat ends there.
// A walk scans each edge slot by a stack read, an edge read, a wait and a step,
// with a push state for each push and a fresh stack read after each stack pop.
// Reset and clear: marks and head valid bits are flip-flops, so both clear at
// once; the head, edge and stack memories need no clearing.
// Stalls: input is not ready while busy or while a beat waits at the output. A
// push waits while the held node and the output register are both full, and the
// final beat of a walk waits for an empty output register.
module graph_depth_first_walk_top #(
  parameter int NODES      = gdfw_pkg::NODES_DEF,
  parameter int EDGE_SLOTS = gdfw_pkg::EDGE_SLOTS_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire [15:0] in_tdata,   // node_a [5:0], node_b [11:6], zero fill
  input  wire [1:0]  in_tuser,   // kind
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [7:0] out_tdata,  // visited_node [5:0], zero fill
  output logic       out_tlast,  // last
  output logic       out_tuser   // overflow
);
  localparam int NW = gdfw_pkg::NODE_W;
  localparam int LW = $clog2(EDGE_SLOTS + 1);   // link: 0 null, s+1 slot s
  localparam int SW = $clog2(EDGE_SLOTS);
  localparam int DW = $clog2(NODES + 1);
  localparam int XW = (NODES > 1) ? $clog2(NODES) : 1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_ADD1  = 8'b00000010,  // write slot for a, head[a]
    S_ADD2  = 8'b00000100,  // write slot for b, head[b]
    S_TOP   = 8'b00001000,  // stack top read pending
    S_EDGE  = 8'b00010000,  // edge read pending
    S_STEP  = 8'b00100000,  // decide on neighbor
    S_EMIT  = 8'b01000000,  // issue stack top read
    S_PUSH  = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;

  // Chain heads live in a memory; a flip-flop valid bit per node makes an
  // unwritten head read as null. Marks are a flip-flop vector.
  logic [LW-1:0] head_mem [NODES];
  logic [LW-1:0] head_q_r;
  logic          hv_q_r;
  logic [NODES-1:0] mark_r, head_v_r;

  // Edge memory (target, link) and stack memory (node, cursor).
  logic [NW+LW-1:0] edge_mem [EDGE_SLOTS];
  logic [NW+LW-1:0] edge_q_r;
  logic [NW+LW-1:0] stk_mem [NODES];
  logic [NW+LW-1:0] stk_q_r;

  logic [LW-1:0] fill_r;
  logic [DW-1:0] depth_r;
  logic          ovf_r;
  logic [NW-1:0] a_r, b_r, nd_r, top_r;
  logic [DW-1:0] cnt_r;
  logic          pend_r;     // a node waits to be emitted
  logic [NW-1:0] pend_n_r;

  wire [NW-1:0] in_a = in_tdata[NW-1:0];
  wire [NW-1:0] in_b = in_tdata[2*NW-1:NW];
  wire in_fire  = in_tvalid && in_tready;
  wire out_fire = out_tvalid && out_tready;

  wire [LW-1:0] head_val  = hv_q_r ? head_q_r : '0;
  wire [LW-1:0] edge_link = edge_q_r[LW-1:0];
  wire [NW-1:0] edge_tgt  = edge_q_r[NW+LW-1:LW];
  wire nxt_ok = (32'(edge_tgt) < NODES) && !mark_r[edge_tgt[XW-1:0]]
                && (32'(cnt_r) < NODES);

  assign in_tready = (state_r == S_IDLE) && !out_tvalid;

  // Output register. The last flag is known only when the walk ends, so one
  // node is held back in pend until the next emission or the walk's end.
  logic          ov_r, ol_r;
  logic [NW-1:0] on_r;
  assign out_tvalid = ov_r;
  assign out_tdata  = 8'(on_r);
  assign out_tlast  = ol_r;
  assign out_tuser  = ovf_r;

  logic stk_we;
  logic [XW-1:0] stk_wa;
  logic [NW+LW-1:0] stk_wd;
  logic edge_we;
  logic edge_re;
  logic [SW-1:0] edge_a;
  logic [NW+LW-1:0] edge_wd;
  logic stk_re;
  logic head_we, head_re;
  logic [XW-1:0] head_wa, head_ra;

  always_comb begin
    state_nxt = state_r;
    stk_we = 1'b0; stk_wa = '0; stk_wd = '0;
    edge_we = 1'b0; edge_re = 1'b0; edge_a = '0; edge_wd = '0;
    stk_re = 1'b0;
    head_we = 1'b0; head_re = 1'b0; head_wa = '0; head_ra = '0;
    case (state_r)
      S_IDLE: if (in_fire) begin
        head_re = 1'b1; head_ra = in_a[XW-1:0];
        case (gdfw_pkg::kind_t'(in_tuser))
          gdfw_pkg::KIND_ADD:
            if (32'(in_a) < NODES && 32'(in_b) < NODES
                && 32'(fill_r) + 2 <= EDGE_SLOTS) state_nxt = S_ADD1;
          gdfw_pkg::KIND_RUN:
            if (32'(in_a) < NODES && !mark_r[in_a[XW-1:0]]) state_nxt = S_PUSH;
          default: ;
        endcase
      end
      S_ADD1: begin
        edge_we = 1'b1; edge_a = fill_r[SW-1:0];
        edge_wd = {b_r, head_val};
        head_we = 1'b1; head_wa = a_r[XW-1:0];
        head_re = 1'b1; head_ra = b_r[XW-1:0];
        state_nxt = S_ADD2;
      end
      S_ADD2: begin
        // A self loop links to the head written in S_ADD1, which the head read cannot see.
        edge_we = 1'b1; edge_a = SW'(fill_r);
        edge_wd = {a_r, (a_r == b_r) ? fill_r : head_val};
        head_we = 1'b1; head_wa = b_r[XW-1:0];
        state_nxt = S_IDLE;
      end
      S_PUSH: if (!pend_r || !ov_r) begin
        stk_we = 1'b1; stk_wa = depth_r[XW-1:0];
        stk_wd = {nd_r, head_val};
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        stk_re = 1'b1; state_nxt = S_TOP;
      end
      S_TOP: begin
        if (stk_q_r[LW-1:0] == '0 || 32'(stk_q_r[LW-1:0]) > EDGE_SLOTS) begin
          if (depth_r == DW'(1)) begin
            if (!ov_r) state_nxt = S_IDLE;
          end else state_nxt = S_EMIT;
        end else begin
          edge_re = 1'b1;
          edge_a = SW'(stk_q_r[LW-1:0] - LW'(1));
          state_nxt = S_EDGE;
        end
      end
      S_EDGE: state_nxt = S_STEP;
      S_STEP: begin
        stk_we = 1'b1; stk_wa = XW'(depth_r - DW'(1));
        stk_wd = {top_r, edge_link};
        head_re = 1'b1; head_ra = edge_tgt[XW-1:0];
        state_nxt = nxt_ok ? S_PUSH : S_EMIT;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Read address for the stack: current top.
  wire [XW-1:0] stk_ra = XW'(depth_r - DW'(1));
  wire at_null = (state_r == S_TOP) &&
                 (stk_q_r[LW-1:0] == '0 || 32'(stk_q_r[LW-1:0]) > EDGE_SLOTS);
  // The bottom frame is popped only once the output register is free.
  wire pop = at_null && !(depth_r == DW'(1) && ov_r);
  wire walk_end = pop && depth_r == DW'(1);

  always_ff @(posedge clk) begin
    if (edge_we) edge_mem[edge_a] <= edge_wd;
    if (edge_re) edge_q_r <= edge_mem[edge_a];
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (stk_re) stk_q_r <= stk_mem[stk_ra];
    if (head_we) head_mem[head_wa] <= fill_r + LW'(1);
    if (head_re) begin
      head_q_r <= head_mem[head_ra];
      hv_q_r <= head_v_r[head_ra];
    end
    if (state_r == S_TOP) top_r <= stk_q_r[NW+LW-1:LW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; mark_r <= '0; head_v_r <= '0; fill_r <= '0;
      depth_r <= '0; ovf_r <= 1'b0; cnt_r <= '0; pend_r <= 1'b0; ov_r <= 1'b0;
      ol_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_fire) ov_r <= 1'b0;
      if (in_fire) begin
        a_r <= in_a; b_r <= in_b; nd_r <= in_a;
        case (gdfw_pkg::kind_t'(in_tuser))
          gdfw_pkg::KIND_CLEAR: begin
            mark_r <= '0; head_v_r <= '0; fill_r <= '0; ovf_r <= 1'b0;
          end
          gdfw_pkg::KIND_ADD:
            if (32'(in_a) < NODES && 32'(in_b) < NODES
                && 32'(fill_r) + 2 > EDGE_SLOTS) ovf_r <= 1'b1;
          gdfw_pkg::KIND_RUN: begin
            depth_r <= '0; cnt_r <= '0;
          end
          default: ;
        endcase
      end
      if (head_we) begin
        head_v_r[head_wa] <= 1'b1;
        fill_r <= fill_r + LW'(1);
      end
      if (state_r == S_PUSH && (!pend_r || !ov_r)) begin
        mark_r[nd_r[XW-1:0]] <= 1'b1;
        if (32'(depth_r) < NODES) depth_r <= depth_r + DW'(1);
        cnt_r <= cnt_r + DW'(1);
        if (pend_r) begin
          ov_r <= 1'b1; on_r <= pend_n_r; ol_r <= 1'b0;
        end
        pend_r <= 1'b1; pend_n_r <= nd_r;
      end
      if (state_r == S_STEP) nd_r <= edge_tgt;
      if (pop) depth_r <= depth_r - DW'(1);
      if (walk_end) begin
        ov_r <= 1'b1; on_r <= pend_n_r; ol_r <= 1'b1; pend_r <= 1'b0;
      end
    end
  end

  // A held node is flushed only into an empty output register.
  a_flush_free: assert property (@(posedge clk) disable iff (!rst_n)
    walk_end |-> !ov_r || out_tready) else $error("flush overwrote output");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> state_r == S_IDLE) else $error("accept while busy");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= EDGE_SLOTS) else $error("edge fill beyond capacity");
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_r) else $error("node held while idle");
endmodule
`default_nettype wire
